@@ rtl/crc8fc_pkg.sv @@
`default_nettype none

package crc8fc_pkg;

	localparam int FRAME_BYTES_DEF = 32;

	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_TOP  = 8'h80;

	localparam logic [7:0] HEADER_RST      = 8'hA5;
	localparam logic [4:0] MAX_PAYLOAD_RST = 5'd28;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_VALUE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_HEADER = 3'd1,
		ST_SEQ    = 3'd2,
		ST_LENGTH = 3'd3,
		ST_CRC    = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
		logic [7:0] exp_seq;
	} crc8fc_in_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] frame_seq;
		logic [7:0] payload_length;
		logic [7:0] computed_crc;
	} crc8fc_out_t;

	// MSB-first CRC-8 update over one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data_in);
		logic [7:0] crc;
		logic [7:0] data;
		logic       mix;
		crc  = crc_in;
		data = data_in;
		for (int b = 0; b < 8; b++) begin
			mix  = crc[7] ^ data[7];
			crc  = {crc[6:0], 1'b0};
			if (mix) begin
				crc = crc ^ CRC_POLY;
			end
			data = {data[6:0], 1'b0};
		end
		return crc;
	endfunction

endpackage

`default_nettype wire

@@ rtl/crc8fc_if.sv @@
`default_nettype none

interface crc8fc_in_if import crc8fc_pkg::*; ();
	logic       valid;
	logic       ready;
	crc8fc_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface crc8fc_out_if import crc8fc_pkg::*; ();
	logic        valid;
	logic        ready;
	crc8fc_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/crc8_frame_checker.sv @@
`default_nettype none

// CRC-8 framed packet checker.
// in_ch  : one received byte per transfer, with a frame start flag and the
//          sequence number expected at position one.
// out_ch : one result per frame, after the last byte: status (first failing
//          check: header, sequence, length, crc), sequence and length bytes
//          and the CRC-8 (poly 0x07, init 0, MSB first) over all but the last.
// cfg    : plain write port, index 0 header value, index 1 max payload.
//          Write only while no byte is in flight.
// Path: a byte goes into an input register, then the CRC update and the
//          compares run combinationally into the result register, from which
//          the result transfers once out_ch is ready.
// Throughput: one byte per cycle, except that a frame's last byte waits until
//          the result register is free; the CRC update is bytewise.
// Reset: position, CRC and error state cleared, registers take their
//          defaults (header 0xA5, max payload 28); framing starts at byte 0.
// Stall: the result register holds until taken; bytes of the next frame keep
//          flowing until its last byte reaches the input register, where it
//          waits, and in_ch.ready drops.
module crc8_frame_checker import crc8fc_pkg::*; #(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	crc8fc_in_if.sink            in_ch,
	crc8fc_out_if.source         out_ch,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [7:0]            cfg_wdata
);

	localparam int POS_W = $clog2(FRAME_BYTES);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

	// configuration
	logic [7:0] header_value_q;
	logic [4:0] max_payload_q;

	// input register
	logic       valid_s1;
	crc8fc_in_t data_s1;

	// frame state
	logic [POS_W-1:0] pos_q;
	logic [7:0]       crc_q;
	status_t          err_q;
	logic [7:0]       seen_seq_q;
	logic [7:0]       seen_len_q;

	// result register
	logic        out_valid_q;
	crc8fc_out_t out_data_q;

	// stage logic
	logic [POS_W-1:0] pos;
	logic [7:0]       crc_base;
	status_t          err_base;
	status_t          err_step;
	status_t          err_final;
	logic             is_last;
	logic             out_free;
	logic             advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_value_q <= HEADER_RST;
			max_payload_q  <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEADER_VALUE: header_value_q <= cfg_wdata;
				CFG_MAX_PAYLOAD:  max_payload_q  <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		pos      = data_s1.frame_start ? '0 : pos_q;
		crc_base = (pos == '0) ? 8'h00 : crc_q;
		err_base = (pos == '0) ? ST_OK : err_q;
		err_step = err_base;
		if (err_base == ST_OK) begin
			if (pos == '0) begin
				if (data_s1.rx_byte != header_value_q) begin
					err_step = ST_HEADER;
				end
			end else if (pos == POS_W'(1)) begin
				if (data_s1.rx_byte != data_s1.exp_seq) begin
					err_step = ST_SEQ;
				end
			end else if (pos == POS_W'(2)) begin
				if (data_s1.rx_byte > {3'b000, max_payload_q}) begin
					err_step = ST_LENGTH;
				end
			end
		end
		is_last   = (pos == LAST_POS);
		err_final = err_step;
		if (err_step == ST_OK && data_s1.rx_byte != crc_base) begin
			err_final = ST_CRC;
		end
	end

	assign out_free    = !out_valid_q || out_ch.ready;
	// a result-bearing byte waits for a free result register
	assign advance     = valid_s1 && (!is_last || out_free);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			data_s1 <= in_ch.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			crc_q      <= 8'h00;
			err_q      <= ST_OK;
			seen_seq_q <= 8'h00;
			seen_len_q <= 8'h00;
		end else if (advance) begin
			if (pos == POS_W'(1)) begin
				seen_seq_q <= data_s1.rx_byte;
			end
			if (pos == POS_W'(2)) begin
				seen_len_q <= data_s1.rx_byte;
			end
			if (is_last) begin
				pos_q <= '0;
				crc_q <= 8'h00;
				err_q <= ST_OK;
			end else begin
				pos_q <= pos + POS_W'(1);
				crc_q <= crc8_byte(crc_base, data_s1.rx_byte);
				err_q <= err_step;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_last) begin
			out_data_q.status         <= err_final;
			out_data_q.frame_seq      <= seen_seq_q;
			out_data_q.payload_length <= seen_len_q;
			out_data_q.computed_crc   <= crc_base;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

	// position never runs past the last byte of a frame
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_POS)
		else $error("byte position beyond frame end");

	// crc failure is only decided at the last byte, never carried
	a_no_stored_crc_err: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != ST_CRC)
		else $error("crc error held in frame state");

	// a new result appears only after the last byte was processed
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && is_last))
		else $error("result without a finished frame");

	// finishing a frame restarts the frame state
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_last) |=> (pos_q == '0 && crc_q == 8'h00 && err_q == ST_OK))
		else $error("frame state not restarted after last byte");

endmodule

`default_nettype wire

@@ test/crc8fc_verdict_check.sv @@
`timescale 1ns / 1ps

// Watches the byte and result channels and the register write port, keeps
// its own model of the frame checker and compares every result transfer
// against the oldest predicted verdict.
module crc8fc_verdict_check import crc8fc_pkg::*; #(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	crc8fc_in_if                in_ch,
	crc8fc_out_if               out_ch,
	input  wire                 cfg_we,
	input  wire [CFG_IDX_W-1:0] cfg_index,
	input  wire [7:0]           cfg_wdata,
	output int                  fail_count,
	output int                  pending
);

	logic [7:0]  hdr_val;
	logic [4:0]  max_len;
	logic [4:0]  pos;
	logic [7:0]  crc_acc;
	status_t     err;
	logic [7:0]  seq_seen;
	logic [7:0]  len_seen;
	crc8fc_out_t verdicts_due[$];

	// bytewise form: fold the data in first, then shift eight times
	function automatic logic [7:0] crc_after_byte(input logic [7:0] c, input logic [7:0] d);
		logic [7:0] r;
		r = c ^ d;
		for (int k = 0; k < 8; k++) begin
			r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

	function automatic void note_first(input status_t code);
		if (err == ST_OK) begin
			err = code;
		end
	endfunction

	function automatic void step_frame_byte(input crc8fc_in_t b);
		crc8fc_out_t v;
		if (b.frame_start) begin
			pos = '0;
		end
		if (pos == 5'd0) begin
			crc_acc = '0;
			err     = ST_OK;
			if (b.rx_byte != hdr_val) begin
				note_first(ST_HEADER);
			end
		end else if (pos == 5'd1) begin
			seq_seen = b.rx_byte;
			if (b.rx_byte != b.exp_seq) begin
				note_first(ST_SEQ);
			end
		end else if (pos == 5'd2) begin
			len_seen = b.rx_byte;
			if (b.rx_byte > {3'b000, max_len}) begin
				note_first(ST_LENGTH);
			end
		end
		if (int'(pos) < FRAME_BYTES - 1) begin
			crc_acc = crc_after_byte(crc_acc, b.rx_byte);
			pos     = pos + 5'd1;
		end else begin
			if (b.rx_byte != crc_acc) begin
				note_first(ST_CRC);
			end
			v.status         = err;
			v.frame_seq      = seq_seen;
			v.payload_length = len_seen;
			v.computed_crc   = crc_acc;
			verdicts_due.push_back(v);
			pos     = '0;
			crc_acc = '0;
			err     = ST_OK;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		crc8fc_out_t want;
		crc8fc_out_t got;
		if (!arst_n) begin
			hdr_val    = HEADER_RST;
			max_len    = MAX_PAYLOAD_RST;
			pos        = '0;
			crc_acc    = '0;
			err        = ST_OK;
			seq_seen   = '0;
			len_seen   = '0;
			fail_count = 0;
			verdicts_due.delete();
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (verdicts_due.size() == 0) begin
					$error("unexpected result: status %0d seq %0d length %0d crc %0h",
						got.status, got.frame_seq, got.payload_length, got.computed_crc);
					fail_count++;
				end else begin
					want = verdicts_due.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fail_count++;
					end
					if (got.frame_seq !== want.frame_seq) begin
						$error("frame_seq: expected %0d, got %0d", want.frame_seq,
							got.frame_seq);
						fail_count++;
					end
					if (got.payload_length !== want.payload_length) begin
						$error("payload_length: expected %0d, got %0d", want.payload_length,
							got.payload_length);
						fail_count++;
					end
					if (got.computed_crc !== want.computed_crc) begin
						$error("computed_crc: expected %0h, got %0h", want.computed_crc,
							got.computed_crc);
						fail_count++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				step_frame_byte(in_ch.data);
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_HEADER_VALUE: hdr_val = cfg_wdata;
					CFG_MAX_PAYLOAD:  max_len = cfg_wdata[4:0];
					default: ;
				endcase
			end
		end
		pending = verdicts_due.size();
	end

endmodule

@@ test/tb_crc8_frame_checker.sv @@
`timescale 1ns / 1ps

// Top of the frame checker bench. Builds frames (good ones and ones with
// chosen faults), stray fragments and noise, drives them a byte per transfer
// with random idling on both sides, and hands all checking to the verdict
// checker beside the block. Register settings change between phases only,
// once the block has drained.
module tb_crc8_frame_checker;
	import crc8fc_pkg::*;

	localparam int FRAME        = FRAME_BYTES_DEF;
	localparam int IDLE_PCT     = 31;
	localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
	localparam int DRAIN_CYCLES = 6;     // input reg + result reg, with margin
	localparam int STALL_LIMIT  = 2000;  // cycles with no transfer at all
	localparam int RANDOM_BYTES = 1200;
	localparam int PHASES       = 5;

	// fault to plant in a built frame; FL_ALL breaks every check at once
	typedef enum int {
		FL_NONE,
		FL_HEADER,
		FL_SEQ,
		FL_LENGTH,
		FL_CRC,
		FL_ALL
	} flaw_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_wdata;

	bit         gaps_on      = 1'b1;  // random idling on both sides
	bit         hold_results = 1'b0;  // asks the receiver for a long hold-off
	logic [7:0] hdr_cur      = HEADER_RST;
	logic [4:0] max_cur      = MAX_PAYLOAD_RST;
	int         bytes_sent   = 0;
	int         idle_run     = 0;
	int         fail_count;
	int         pending;

	crc8fc_in_if  in_ch ();
	crc8fc_out_if out_ch ();

	crc8_frame_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	crc8fc_verdict_check checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: any transfer on either side resets the count.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_run <= 0;
		end else begin
			idle_run <= idle_run + 1;
			if (idle_run + 1 >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Result side. Ready changes on the falling edge; a hold-off request
	// keeps it low for HOLD_CYCLES, counted here, while the sender carries on.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_results) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_results = 1'b0;
			end
			out_ch.ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Offer one byte from a falling edge and hold it until the transfer.
	// Valid stays high on return so back-to-back bytes need no gap.
	task automatic offer_byte(input logic [7:0] b, input bit st, input logic [7:0] es);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= crc8fc_in_t'{rx_byte: b, frame_start: st, exp_seq: es};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Full frame. len < 0 picks a length at random, legal unless the fault
	// calls for an oversize one. exp_seq only matters at position one,
	// so it is random junk elsewhere.
	task automatic send_frame(input flaw_t flaw, input bit with_start, input int len);
		logic [7:0] fb [FRAME];
		logic [7:0] seq;
		logic [7:0] acc;
		seq   = 8'($urandom);
		fb[0] = hdr_cur;
		fb[1] = seq;
		if (flaw == FL_HEADER || flaw == FL_ALL) begin
			fb[0] = fb[0] ^ 8'($urandom_range(255, 1));
		end
		if (flaw == FL_SEQ || flaw == FL_ALL) begin
			fb[1] = fb[1] ^ 8'($urandom_range(255, 1));
		end
		if (len >= 0) begin
			fb[2] = 8'(len);
		end else if (flaw == FL_LENGTH || flaw == FL_ALL) begin
			fb[2] = 8'($urandom_range(255, max_cur + 1));
		end else begin
			fb[2] = 8'($urandom_range(max_cur, 0));
		end
		for (int i = 3; i < FRAME - 1; i++) begin
			fb[i] = 8'($urandom);
		end
		acc = '0;
		for (int i = 0; i < FRAME - 1; i++) begin
			acc = crc8_byte(acc, fb[i]);
		end
		fb[FRAME-1] = acc;
		if (flaw == FL_CRC || flaw == FL_ALL) begin
			fb[FRAME-1] = acc ^ 8'($urandom_range(255, 1));
		end
		for (int i = 0; i < FRAME; i++) begin
			offer_byte(fb[i], with_start && (i == 0), (i == 1) ? seq : 8'($urandom));
		end
	endtask

	// Fragment opened with a start flag and cut short, with the odd stray
	// start flag inside: the block must drop it without a result.
	task automatic send_stray(input int n);
		for (int i = 0; i < n; i++) begin
			offer_byte((i == 0) ? hdr_cur : 8'($urandom), (i == 0) || ($urandom_range(15) == 0),
				8'($urandom));
		end
	endtask

	// Mostly well-formed frames, some with one fault or with every fault, some fragments.
	// After a fragment the next frame must realign with a start flag.
	task automatic run_random(input int nbytes);
		int goal;
		int pick;
		bit aligned;
		goal    = bytes_sent + nbytes;
		aligned = 1'b1;
		while (bytes_sent < goal) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				send_frame(FL_NONE, !aligned || ($urandom_range(1) == 1), -1);
				aligned = 1'b1;
			end else if (pick < 88) begin
				send_frame(flaw_t'($urandom_range(FL_ALL, FL_HEADER)),
					!aligned || ($urandom_range(1) == 1), -1);
				aligned = 1'b1;
			end else begin
				send_stray($urandom_range(FRAME - 1, 1));
				aligned = 1'b0;
			end
		end
	endtask

	// Drop valid and wait for every predicted result, then let the
	// pipeline empty of bytes that produce none.
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [7:0] ph_hdr;
		logic [4:0] ph_max;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_wdata   = '0;
		in_ch.valid = 1'b0;
		in_ch.data  = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, on reset defaults. First frame has no start flag at all,
		// the second follows back-to-back, also without one.
		send_frame(FL_NONE, 1'b0, MAX_PAYLOAD_RST);
		send_frame(FL_NONE, 1'b0, 0);
		send_frame(FL_ALL, 1'b1, -1);           // only the header fault reported
		send_frame(FL_SEQ, 1'b0, -1);
		send_frame(FL_LENGTH, 1'b0, 255);
		send_frame(FL_LENGTH, 1'b1, MAX_PAYLOAD_RST + 1);
		send_frame(FL_CRC, 1'b0, -1);
		send_stray(10);                         // start flag mid-frame drops this
		send_frame(FL_NONE, 1'b1, -1);
		send_stray(FRAME - 1);                  // cut one byte short of a result
		send_frame(FL_NONE, 1'b1, -1);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					ph_hdr = 8'h00;
					ph_max = 5'd0;
				end
				1: begin
					ph_hdr = 8'hFF;
					ph_max = MAX_PAYLOAD_RST;
				end
				PHASES - 1: begin
					ph_hdr = HEADER_RST;
					ph_max = MAX_PAYLOAD_RST;
				end
				default: begin
					ph_hdr = 8'($urandom);
					ph_max = 5'($urandom_range(MAX_PAYLOAD_RST, 0));
				end
			endcase
			settle();
			write_cfg(CFG_HEADER_VALUE, ph_hdr);
			write_cfg(CFG_MAX_PAYLOAD, {3'b000, ph_max});
			hdr_cur = ph_hdr;
			max_cur = ph_max;
			gaps_on = (ph != 3);                // phase 3 runs flat out
			if (ph == 1) begin
				hold_results = 1'b1;             // back-pressure until input stalls
			end
			run_random(RANDOM_BYTES / (2 * PHASES));
			if (ph == 2) begin
				settle();                         // sender waits for every result
			end
			run_random(RANDOM_BYTES / (2 * PHASES));
		end

		gaps_on = 1'b1;
		settle();
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ crc8_frame_checker.f @@
rtl/crc8fc_pkg.sv
rtl/crc8fc_if.sv
rtl/crc8_frame_checker.sv
test/crc8fc_verdict_check.sv
test/tb_crc8_frame_checker.sv
